// File: rtl/core/spt_pkg.sv
// Shared types and constants of the spiral tile order generator.
package spt_pkg;

   localparam int unsigned GRID_W    = 8;
   localparam int unsigned POINT_W   = 12;
   localparam int unsigned SHIFT_W   = 3;
   localparam int unsigned WALK_W    = 11;
   localparam int unsigned RUN_W     = 10;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // heading codes
   localparam logic [1:0] HEAD_RIGHT = 2'd0;
   localparam logic [1:0] HEAD_DOWN  = 2'd1;
   localparam logic [1:0] HEAD_LEFT  = 2'd2;
   localparam logic [1:0] HEAD_UP    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT  = 2'd2;

   // register reset values
   localparam logic [GRID_W-1:0]  GRID_WIDTH_RESET  = 8'd240;
   localparam logic [GRID_W-1:0]  GRID_HEIGHT_RESET = 8'd135;
   localparam logic [SHIFT_W-1:0] TILE_SHIFT_RESET  = 3'd3;

   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic               command;
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [GRID_W-1:0] tile_x;
      logic [GRID_W-1:0] tile_y;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [GRID_W-1:0]  grid_width;
      logic [GRID_W-1:0]  grid_height;
      logic [SHIFT_W-1:0] tile_shift;
   } cfg_type;

   // start tile after shift and clamp; ok is low for an empty grid
   typedef struct packed {
      logic              ok;
      logic [GRID_W-1:0] tile_x;
      logic [GRID_W-1:0] tile_y;
   } start_type;

   // walker result toward the output register
   typedef struct packed {
      logic    emit;
      rsp_type tile;
   } walk_out_type;

endpackage

// File: rtl/core/spt_start.sv
// Start tile mapping: pixel point to tile by shift, clamped into the grid.
module spt_start (
   input  spt_pkg::req_type   item,
   input  spt_pkg::cfg_type   cfg,
   output spt_pkg::start_type start
);

   logic [spt_pkg::POINT_W-1:0] shifted_x;
   logic [spt_pkg::POINT_W-1:0] shifted_y;
   logic [spt_pkg::GRID_W-1:0]  max_x;
   logic [spt_pkg::GRID_W-1:0]  max_y;

   assign shifted_x = item.point_x >> cfg.tile_shift;
   assign shifted_y = item.point_y >> cfg.tile_shift;
   assign max_x     = cfg.grid_width - 8'd1;
   assign max_y     = cfg.grid_height - 8'd1;

   always_comb begin
      start.ok = (cfg.grid_width != '0) && (cfg.grid_height != '0);
      if (shifted_x > {4'd0, max_x}) begin
         start.tile_x = max_x;
      end else begin
         start.tile_x = shifted_x[spt_pkg::GRID_W-1:0];
      end
      if (shifted_y > {4'd0, max_y}) begin
         start.tile_y = max_y;
      end else begin
         start.tile_y = shifted_y[spt_pkg::GRID_W-1:0];
      end
   end

endmodule

// File: rtl/core/spt_walker.sv
// Spiral walk state, one position per step, grid test and completion count.
module spt_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  spt_pkg::req_type      item,
   input  spt_pkg::cfg_type      cfg,
   input  spt_pkg::start_type    start,
   output spt_pkg::walk_out_type result
);

   logic [spt_pkg::WALK_W-1:0]  walk_x_ff,  walk_x_in;
   logic [spt_pkg::WALK_W-1:0]  walk_y_ff,  walk_y_in;
   logic [spt_pkg::RUN_W-1:0]   run_len_ff, run_len_in;
   logic [spt_pkg::RUN_W-1:0]   run_pos_ff, run_pos_in;
   logic [1:0]                  heading_ff, heading_in;
   logic [spt_pkg::COUNT_W-1:0] count_ff,   count_in;
   logic                        active_ff,  active_in;

   logic [spt_pkg::COUNT_W-1:0] grid_total;
   logic [spt_pkg::COUNT_W-1:0] count_inc;
   logic [spt_pkg::WALK_W-1:0]  step_x;
   logic [spt_pkg::WALK_W-1:0]  step_y;
   logic [spt_pkg::RUN_W-1:0]   pos_inc;
   logic [1:0]                  heading_inc;
   logic                        in_grid;
   logic                        done;

   assign grid_total = {8'd0, cfg.grid_width} * {8'd0, cfg.grid_height};
   assign count_inc  = (count_ff == spt_pkg::COUNT_MAX) ? count_ff : count_ff + 16'd1;
   assign pos_inc    = run_pos_ff + 10'd1;
   assign heading_inc = heading_ff + 2'd1;

   always_comb begin
      step_x = walk_x_ff;
      step_y = walk_y_ff;
      unique case (heading_ff)
         spt_pkg::HEAD_RIGHT: step_x = walk_x_ff + 11'd1;
         spt_pkg::HEAD_DOWN:  step_y = walk_y_ff + 11'd1;
         spt_pkg::HEAD_LEFT:  step_x = walk_x_ff - 11'd1;
         spt_pkg::HEAD_UP:    step_y = walk_y_ff - 11'd1;
         default:             step_x = walk_x_ff;
      endcase
   end

   // negative positions have the top bit set
   assign in_grid = !step_x[spt_pkg::WALK_W-1] && !step_y[spt_pkg::WALK_W-1]
                    && (step_x[spt_pkg::WALK_W-2:0] < {2'd0, cfg.grid_width})
                    && (step_y[spt_pkg::WALK_W-2:0] < {2'd0, cfg.grid_height});

   always_comb begin
      walk_x_in  = walk_x_ff;
      walk_y_in  = walk_y_ff;
      run_len_in = run_len_ff;
      run_pos_in = run_pos_ff;
      heading_in = heading_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      result.emit        = 1'b0;
      result.tile.tile_x = step_x[spt_pkg::GRID_W-1:0];
      result.tile.tile_y = step_y[spt_pkg::GRID_W-1:0];
      result.tile.last   = 1'b0;
      done = 1'b0;
      if (item.command == spt_pkg::CMD_START) begin
         run_len_in = 10'd1;
         run_pos_in = '0;
         heading_in = spt_pkg::HEAD_RIGHT;
         if (start.ok) begin
            done       = (16'd1 >= grid_total);
            walk_x_in  = {3'd0, start.tile_x};
            walk_y_in  = {3'd0, start.tile_y};
            count_in   = 16'd1;
            active_in  = !done;
            result.emit        = 1'b1;
            result.tile.tile_x = start.tile_x;
            result.tile.tile_y = start.tile_y;
            result.tile.last   = done;
         end else begin
            walk_x_in = '0;
            walk_y_in = '0;
            count_in  = '0;
            active_in = 1'b0;
         end
      end else if (active_ff) begin
         walk_x_in = step_x;
         walk_y_in = step_y;
         if (pos_inc >= run_len_ff) begin
            run_pos_in = '0;
            heading_in = heading_inc;
            // run grows after every second turn
            if (!heading_inc[0] && (run_len_ff != spt_pkg::RUN_MAX)) begin
               run_len_in = run_len_ff + 10'd1;
            end
         end else begin
            run_pos_in = pos_inc;
         end
         if (in_grid) begin
            done        = (count_inc >= grid_total);
            count_in    = count_inc;
            active_in   = !done;
            result.emit = 1'b1;
            result.tile.last = done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff  <= '0;
         walk_y_ff  <= '0;
         run_len_ff <= 10'd1;
         run_pos_ff <= '0;
         heading_ff <= spt_pkg::HEAD_RIGHT;
         count_ff   <= '0;
         active_ff  <= 1'b0;
      end else if (fire) begin
         walk_x_ff  <= walk_x_in;
         walk_y_ff  <= walk_y_in;
         run_len_ff <= run_len_in;
         run_pos_ff <= run_pos_in;
         heading_ff <= heading_in;
         count_ff   <= count_in;
         active_ff  <= active_in;
      end
   end

endmodule

// File: rtl/core/spiral_tile_order_generator.sv
// Spiral tile order generator: input register, spiral walker, result register.
// The input register holds a request and the result register its result,
// which drives rsp_valid. Throughput: one request per cycle unless a stalled
// result holds it; the walker advances one spiral position per request and
// holds the whole step in one register-to-register path.
// Reset (synchronous): walker idle, both stages empty, registers back to
// 240 x 135 tiles of 8 pixels.
module spiral_tile_order_generator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  spt_pkg::req_type                  req_payload,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output spt_pkg::rsp_type                  rsp_payload,
   // configuration writes
   input  logic                              csr_write_enable,
   input  logic [spt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spt_pkg::GRID_W-1:0]        csr_write_data
);

   spt_pkg::cfg_type      cfg_ff;
   spt_pkg::req_type      in_item_ff;
   logic                  in_valid_ff;
   spt_pkg::rsp_type      out_item_ff;
   logic                  out_valid_ff;

   spt_pkg::start_type    start;
   spt_pkg::walk_out_type walk_out;
   logic                  fire;

   // The held request is processed once the result register is free or
   // being drained this cycle; items with no result also wait for that.
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // configuration registers; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= spt_pkg::GRID_WIDTH_RESET;
         cfg_ff.grid_height <= spt_pkg::GRID_HEIGHT_RESET;
         cfg_ff.tile_shift  <= spt_pkg::TILE_SHIFT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == spt_pkg::CSR_GRID_WIDTH) begin
            cfg_ff.grid_width <= csr_write_data;
         end
         if (csr_index == spt_pkg::CSR_GRID_HEIGHT) begin
            cfg_ff.grid_height <= csr_write_data;
         end
         if (csr_index == spt_pkg::CSR_TILE_SHIFT) begin
            cfg_ff.tile_shift <= csr_write_data[spt_pkg::SHIFT_W-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   spt_start u_start (
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .start (start)
   );

   spt_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .start  (start),
      .result (walk_out)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= walk_out.emit;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && walk_out.emit) begin
         out_item_ff <= walk_out.tile;
      end
   end

endmodule

// File: bench/spiral_tile_order_checker.sv
// Checker for the spiral tile order generator: predicts each tile and compares transfers.
`timescale 1ns / 1ps
module spiral_tile_order_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  spt_pkg::req_type              req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  spt_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [spt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spt_pkg::GRID_W-1:0]    csr_write_data,
   output int unsigned                   mismatch_count,
   output int unsigned                   tiles_pending,
   output int unsigned                   walk_items,
   output int unsigned                   tiles_seen,
   output int unsigned                   grids_done
);

   spt_pkg::cfg_type            grid_cfg;
   logic [spt_pkg::WALK_W-1:0]  pos_x;
   logic [spt_pkg::WALK_W-1:0]  pos_y;
   logic [spt_pkg::RUN_W-1:0]   leg_length;
   logic [spt_pkg::RUN_W-1:0]   leg_step;
   logic [1:0]                  direction;
   logic [spt_pkg::COUNT_W-1:0] tile_count;
   logic                        walking;
   spt_pkg::rsp_type            expected_tiles[$];
   spt_pkg::rsp_type            due;
   int unsigned                 errors;
   int unsigned                 items_taken;
   int unsigned                 tiles_got;
   int unsigned                 grids_got;

   // count the tile, flag the one that covers the whole grid
   task automatic claim_tile(input logic [spt_pkg::GRID_W-1:0] tx,
                             input logic [spt_pkg::GRID_W-1:0] ty);
      spt_pkg::rsp_type tile;
      if (tile_count != spt_pkg::COUNT_MAX)
         tile_count = tile_count + 1'b1;
      tile.tile_x = tx;
      tile.tile_y = ty;
      tile.last   = (32'(tile_count) >=
                     32'(grid_cfg.grid_width) * 32'(grid_cfg.grid_height));
      if (tile.last)
         walking = 1'b0;
      expected_tiles = {expected_tiles, tile};
   endtask

   task automatic walk_spiral(input spt_pkg::req_type item);
      logic [spt_pkg::POINT_W-1:0] col;
      logic [spt_pkg::POINT_W-1:0] row;
      if (item.command == spt_pkg::CMD_START) begin
         items_taken++;
         leg_length = spt_pkg::RUN_W'(1);
         leg_step   = '0;
         direction  = spt_pkg::HEAD_RIGHT;
         tile_count = '0;
         if (grid_cfg.grid_width == 0 || grid_cfg.grid_height == 0) begin
            pos_x   = '0;
            pos_y   = '0;
            walking = 1'b0;
         end else begin
            col = item.point_x >> grid_cfg.tile_shift;
            row = item.point_y >> grid_cfg.tile_shift;
            if (col >= spt_pkg::POINT_W'(grid_cfg.grid_width))
               col = spt_pkg::POINT_W'(grid_cfg.grid_width) - 1'b1;
            if (row >= spt_pkg::POINT_W'(grid_cfg.grid_height))
               row = spt_pkg::POINT_W'(grid_cfg.grid_height) - 1'b1;
            pos_x   = spt_pkg::WALK_W'(col);
            pos_y   = spt_pkg::WALK_W'(row);
            walking = 1'b1;
            claim_tile(col[spt_pkg::GRID_W-1:0], row[spt_pkg::GRID_W-1:0]);
         end
      end else if (walking) begin
         items_taken++;
         case (direction)
            spt_pkg::HEAD_RIGHT: pos_x = pos_x + 1'b1;
            spt_pkg::HEAD_DOWN:  pos_y = pos_y + 1'b1;
            spt_pkg::HEAD_LEFT:  pos_x = pos_x - 1'b1;
            default:             pos_y = pos_y - 1'b1;
         endcase
         leg_step = leg_step + 1'b1;
         if (leg_step >= leg_length) begin
            leg_step  = '0;
            direction = direction + 1'b1;
            if (!direction[0] && leg_length != spt_pkg::RUN_MAX)
               leg_length = leg_length + 1'b1;
         end
         // negative positions have the top bit set
         if (!pos_x[spt_pkg::WALK_W-1] && !pos_y[spt_pkg::WALK_W-1] &&
             pos_x < spt_pkg::WALK_W'(grid_cfg.grid_width) &&
             pos_y < spt_pkg::WALK_W'(grid_cfg.grid_height))
            claim_tile(pos_x[spt_pkg::GRID_W-1:0], pos_y[spt_pkg::GRID_W-1:0]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         grid_cfg.grid_width  = spt_pkg::GRID_WIDTH_RESET;
         grid_cfg.grid_height = spt_pkg::GRID_HEIGHT_RESET;
         grid_cfg.tile_shift  = spt_pkg::TILE_SHIFT_RESET;
         pos_x       = '0;
         pos_y       = '0;
         leg_length  = spt_pkg::RUN_W'(1);
         leg_step    = '0;
         direction   = spt_pkg::HEAD_RIGHT;
         tile_count  = '0;
         walking     = 1'b0;
         errors      = 0;
         items_taken = 0;
         tiles_got   = 0;
         grids_got   = 0;
         expected_tiles.delete();
      end else begin
         // result first: a request taken on this edge cannot have produced it
         if (rsp_valid && !rsp_stall) begin
            tiles_got++;
            if (rsp_payload.last)
               grids_got++;
            if (expected_tiles.size() == 0) begin
               errors++;
               $display("%0t: tile expected none, got (%0d,%0d) last %0b", $time,
                        rsp_payload.tile_x, rsp_payload.tile_y, rsp_payload.last);
            end else begin
               due = expected_tiles.pop_front();
               if (rsp_payload.tile_x !== due.tile_x || rsp_payload.tile_y !== due.tile_y ||
                   rsp_payload.last !== due.last) begin
                  errors++;
                  $display("%0t: tile expected (%0d,%0d) last %0b, got (%0d,%0d) last %0b",
                           $time, due.tile_x, due.tile_y, due.last,
                           rsp_payload.tile_x, rsp_payload.tile_y, rsp_payload.last);
               end
            end
         end
         if (req_valid && !req_stall)
            walk_spiral(req_payload);
         if (csr_write_enable) begin
            case (csr_index)
               spt_pkg::CSR_GRID_WIDTH:  grid_cfg.grid_width  = csr_write_data;
               spt_pkg::CSR_GRID_HEIGHT: grid_cfg.grid_height = csr_write_data;
               spt_pkg::CSR_TILE_SHIFT:
                  grid_cfg.tile_shift = csr_write_data[spt_pkg::SHIFT_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      tiles_pending  <= expected_tiles.size();
      walk_items     <= items_taken;
      tiles_seen     <= tiles_got;
      grids_done     <= grids_got;
   end

endmodule

// File: bench/tb_spiral_tile_order_generator.sv
// Testbench top for the spiral tile order generator: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_spiral_tile_order_generator;

   localparam int unsigned ITEM_TARGET   = 1550;       // request transfers over the run
   localparam int unsigned CALM_ITEMS    = 250;        // tail of the run without idling
   localparam int unsigned LONG_HOLD     = 200;        // receiver hold-off, in cycles
   localparam int unsigned SETTLE_CYCLES = 4;          // result passes the input and result registers after transfer
   localparam int unsigned LIMIT_NS      = 5_000_000;
   // index 3 is not mapped; writes to it must leave every register alone
   localparam logic [spt_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   spt_pkg::req_type              req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   spt_pkg::rsp_type              rsp_payload;
   logic                          csr_write_enable;
   logic [spt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [spt_pkg::GRID_W-1:0]    csr_write_data;

   int unsigned          mismatches;
   int unsigned          tiles_pending;
   int unsigned          walk_items;
   int unsigned          tiles_seen;
   int unsigned          grids_done;

   // stimulus-side view of the registers, used to aim points and size walks
   int unsigned                 width_now = 240;
   int unsigned                 height_now = 135;
   logic [spt_pkg::SHIFT_W-1:0] shift_now = 3;
   int unsigned                 items_offered = 0;
   int unsigned                 long_holds = 0;
   bit                          quiet = 1'b0;          // no idling on either side
   bit                          hold_request = 1'b0;   // ask the receiver for one long hold-off

   spiral_tile_order_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   spiral_tile_order_checker order_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatches),
      .tiles_pending    (tiles_pending),
      .walk_items       (walk_items),
      .tiles_seen       (tiles_seen),
      .grids_done       (grids_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a transfer never completes.
   initial begin
      #(LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random stall bursts, stall-free stretches, and one long hold-off on request.
   // Every branch assigns rsp_stall once and then waits on the clock.
   initial begin
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request <= 1'b0;
            long_holds++;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // One request transfer, with an occasional idle burst in front of it.
   // Valid stays high into the next item; the payload holds while stalled.
   task automatic send(input spt_pkg::req_type item);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      items_offered++;
   endtask

   task automatic send_start(input logic [spt_pkg::POINT_W-1:0] px,
                             input logic [spt_pkg::POINT_W-1:0] py);
      spt_pkg::req_type item;
      item.command = spt_pkg::CMD_START;
      item.point_x = px;
      item.point_y = py;
      send(item);
   endtask

   // point fields are don't-care on a step; fill them anyway to toggle every bit
   task automatic send_step();
      spt_pkg::req_type item;
      item.command = spt_pkg::CMD_STEP;
      item.point_x = spt_pkg::POINT_W'($urandom);
      item.point_y = spt_pkg::POINT_W'($urandom);
      send(item);
   endtask

   // Drop valid, wait for the last expected tile, then SETTLE_CYCLES more for steps
   // that are still in the pipe but emit nothing.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tiles_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [spt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [spt_pkg::GRID_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Back-to-back writes to the registers selected by mask; enable drops once at the end.
   task automatic set_grid(input logic [2:0] mask, input int unsigned w, input int unsigned h,
                           input int unsigned shift_data, input bit spare);
      if (mask[0]) begin
         write_reg(spt_pkg::CSR_GRID_WIDTH, spt_pkg::GRID_W'(w));
         width_now = w & 8'hFF;
      end
      if (mask[1]) begin
         write_reg(spt_pkg::CSR_GRID_HEIGHT, spt_pkg::GRID_W'(h));
         height_now = h & 8'hFF;
      end
      if (mask[2]) begin
         write_reg(spt_pkg::CSR_TILE_SHIFT, spt_pkg::GRID_W'(shift_data));
         shift_now = spt_pkg::SHIFT_W'(shift_data);
      end
      if (spare)
         write_reg(CSR_SPARE, spt_pkg::GRID_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // Pixel coordinate: extremes, a spot near the grid (some just past the edge), or anything.
   function automatic logic [spt_pkg::POINT_W-1:0] pick_point(input int unsigned dim);
      int unsigned tile;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: begin
            tile = $urandom_range(0, dim + 1);
            return spt_pkg::POINT_W'((tile << shift_now) |
                                     ($urandom & ((1 << shift_now) - 1)));
         end
         default: return spt_pkg::POINT_W'($urandom);
      endcase
   endfunction

   // Grid size: mostly tiny so walks finish, with empty and full-size grids mixed in.
   function automatic int unsigned pick_dim();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         return 0;
      if (roll <= 2)
         return 255;
      if (roll <= 12)
         return $urandom_range(1, 5);
      if (roll <= 14)
         return $urandom_range(6, 16);
      return $urandom_range(1, 255);
   endfunction

   // Raw write data now and then, so the upper bits that the register drops get exercised.
   function automatic int unsigned pick_shift();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(0, 7);
   endfunction

   // A start followed by steps. On a small grid there are enough steps to sweep it
   // completely and run a few past the last tile; on a large one a short random walk.
   // Now and then the walk is cut short and the next start lands mid-walk.
   // Near the end of the run the steps are trimmed to the remaining item budget.
   task automatic walk_sequence();
      int unsigned span;
      int unsigned steps;
      span = (width_now > height_now) ? width_now : height_now;
      if (width_now == 0 || height_now == 0)
         steps = $urandom_range(0, 4);
      else if (span <= 10 && width_now * height_now <= 64)
         steps = (2 * span + 1) * (2 * span + 1) + $urandom_range(0, 6);
      else
         steps = $urandom_range(4, 80);
      if ($urandom_range(0, 7) == 0)
         steps = $urandom_range(0, steps);
      if (items_offered + 1 + steps > ITEM_TARGET)
         steps = (items_offered + 1 < ITEM_TARGET) ? ITEM_TARGET - items_offered - 1 : 0;
      send_start(pick_point(width_now), pick_point(height_now));
      repeat (steps) send_step();
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= spt_pkg::CSR_GRID_WIDTH;
      csr_write_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, on the reset grid of 240 x 135 tiles of 8 pixels.
      send_step();                    // walker idle: ignored
      send_start('0, '0);             // corner; the spiral leaves the grid to the left and top
      repeat (6) send_step();
      send_start('1, '1);             // beyond the grid: clamped to the far corner
      repeat (3) send_step();
      settle();

      // single tile: the start tile is also the last, later steps are ignored
      set_grid(3'b011, 1, 1, 0, 1'b0);
      send_start(spt_pkg::POINT_W'($urandom), spt_pkg::POINT_W'($urandom));
      send_step();
      settle();

      // empty grid: a start emits nothing
      set_grid(3'b001, 0, 0, 0, 1'b0);
      send_start(spt_pkg::POINT_W'($urandom), spt_pkg::POINT_W'($urandom));
      send_step();
      settle();

      // 2 x 2 grid with the widest shift: three steps complete it, one more is ignored
      set_grid(3'b111, 2, 2, 7, 1'b0);
      send_start(spt_pkg::POINT_W'(1), '0);
      repeat (4) send_step();
      settle();

      // Back pressure: the receiver holds off while a walk on a full grid keeps emitting,
      // so the pipeline fills and the request side stalls.
      set_grid(3'b111, 255, 255, 4, 1'b0);
      hold_request <= 1'b1;
      send_start(spt_pkg::POINT_W'(2040), spt_pkg::POINT_W'(2040));
      repeat (120) send_step();
      settle();

      // Random phases. A phase may open with steps, so a live walk carries over
      // the register change.
      while (items_offered < ITEM_TARGET) begin
         if (!quiet && items_offered + CALM_ITEMS >= ITEM_TARGET)
            quiet <= 1'b1;
         set_grid(3'($urandom_range(1, 7)), pick_dim(), pick_dim(), pick_shift(),
                  $urandom_range(0, 9) == 0);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) send_step();
         repeat ($urandom_range(1, 3)) walk_sequence();
         settle();
      end

      $display("Run covered %0d transfers in (%0d on a live walk) and %0d tiles out,",
               items_offered, walk_items, tiles_seen);
      $display("%0d grids swept to the last tile, %0d long receiver hold-off.",
               grids_done, long_holds);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/spt_pkg.sv
rtl/core/spt_start.sv
rtl/core/spt_walker.sv
rtl/core/spiral_tile_order_generator.sv
bench/spiral_tile_order_checker.sv
bench/tb_spiral_tile_order_generator.sv
